@@ hw/rtl/isrt_pkg.sv @@
package isrt_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;

   // Commands broadcast to every cell of the chain together.
   typedef struct packed {
      logic insert;  // a new value is placed into the chain
      logic shift;   // the chain moves one place towards the output
   } ctrl_type;

endpackage

@@ hw/rtl/insertion_sorter.sv @@
// Streaming stable insertion sorter. Each req_ beat carries one signed value,
// which is written into a chain of CAPACITY cells as its beat is taken: every
// cell compares its entry with the new value at once, and entries greater than
// it move up one place. A beat with req_end_of_set high is inserted like any
// other, after which the set drains from the bottom of the chain, one rsp_ beat
// per cycle while rsp_stall is low, in ascending order, the last beat marked by
// rsp_final_res. Values that arrive while the chain is full are dropped, and
// rsp_overflowed is then high on every beat of that set. Values are taken at one
// per cycle while a set is being collected; while a set drains, req_stall is
// high, so no new value is taken until the last beat of the set has left.
module insertion_sorter
   import isrt_pkg::*;
#(
   parameter int CAPACITY = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_end_of_set,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_final_res,
   output logic                     rsp_overflowed
);

   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;

   logic          req_beat, rsp_beat, full;
   ctrl_type      ctrl;

   logic     [CAPACITY-1:0] gt;
   data_type                 cell_data [CAPACITY];

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign full     = (count_ff == CW'(CAPACITY));

   assign ctrl.insert = req_beat && !full;
   assign ctrl.shift  = rsp_beat;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic     prev_gt;
         data_type prev_data;
         data_type next_data;

         if (i == 0) begin : g_first
            assign prev_gt   = 1'b0;
            assign prev_data = '0;
         end else begin : g_mid
            assign prev_gt   = gt[i-1];
            assign prev_data = cell_data[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign next_data = '0;
         end else begin : g_inner
            assign next_data = cell_data[i+1];
         end

         isrt_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .new_value (req_value),
            .occupied  (CW'(i) < count_ff),
            .at_tail   (CW'(i) == count_ff),
            .prev_gt   (prev_gt),
            .prev_data (prev_data),
            .next_data (next_data),
            .gt        (gt[i]),
            .data      (cell_data[i])
         );
      end
   endgenerate

   assign req_stall        = (state_ff == ST_DRAIN);
   assign rsp_valid        = (state_ff == ST_DRAIN);
   assign rsp_sorted_value = cell_data[0];
   assign rsp_final_res    = (count_ff == CW'(1));
   assign rsp_overflowed   = ovf_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_beat) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CW'(1);
               end
               if (req_end_of_set) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_beat) begin
               count_in = count_ff - CW'(1);
               if (rsp_final_res) begin
                  state_in = ST_FILL;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count beyond capacity");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (count_ff != '0))
      else $error("draining an empty chain");

   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_final_res |=> rsp_valid && (rsp_sorted_value >= $past(rsp_sorted_value)))
      else $error("results not in ascending order");

   a_set_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && rsp_final_res |=> !rsp_valid && (count_ff == '0) && !ovf_ff)
      else $error("set not closed after final beat");
`endif

endmodule

@@ hw/rtl/isrt_cell.sv @@
module isrt_cell
   import isrt_pkg::*;
(
   input  logic     clock,
   input  ctrl_type ctrl,
   input  data_type new_value,
   input  logic     occupied,
   input  logic     at_tail,
   input  logic     prev_gt,
   input  data_type prev_data,
   input  data_type next_data,
   output logic     gt,
   output data_type data
);

   data_type data_ff;
   data_type data_in;

   // Strictly greater keeps equal keys in arrival order.
   assign gt   = occupied && (data_ff > new_value);
   assign data = data_ff;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = next_data;
      end else if (ctrl.insert) begin
         // The lower neighbour is greater too, so its value moves up into this cell.
         if (prev_gt) begin
            data_in = prev_data;
         end else if (gt || at_tail) begin
            data_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

@@ tb/sv/tb_insertion_sorter.sv @@
`timescale 1ns / 100ps

module tb_insertion_sorter;
   import isrt_pkg::*;

   localparam int SORT_CAP     = 32;
   localparam int NUM_ITEMS    = 460;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 2 * SORT_CAP + 20;
   localparam int NUM_PROBES   = 22;

   localparam data_type VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam data_type VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      data_type value;
      logic     last;
      logic     ovf;
   } sorted_beat_type;

   typedef struct packed {
      data_type value;
      logic     end_of_set;
      logic     typed;
      data_type typed_value;
   } probe_row_type;

   logic     clock;
   logic     reset;
   logic     req_valid;
   logic     req_stall;
   data_type req_value;
   logic     req_end_of_set;
   logic     rsp_valid;
   logic     rsp_stall;
   data_type rsp_sorted_value;
   logic     rsp_final_res;
   logic     rsp_overflowed;

   // Travels with the payload so that the monitor knows which beats carry
   // a hand-written expectation.
   logic     beat_typed;
   data_type beat_typed_value;

   // Predicted contents of the sorting chain.
   data_type    held [SORT_CAP];
   int unsigned held_count;
   bit          held_dropped;

   sorted_beat_type sorted_due [$];
   int unsigned     mismatches;
   int unsigned     rsp_seen;
   int unsigned     quiet_cycles;
   bit              send_calm;

   // Typed rows are lone values sent into an empty store, so the prediction
   // for them can be read straight off the row.
   probe_row_type probes [NUM_PROBES] = '{
      '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
      '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
      '{32'sd0, 1'b1, 1'b1, 32'sd0},
      '{-32'sd1, 1'b1, 1'b1, -32'sd1},
      '{32'sd1, 1'b1, 1'b1, 32'sd1},
      '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
      '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
      '{32'sd0, 1'b0, 1'b0, 32'sd0},
      '{-32'sd1, 1'b0, 1'b0, 32'sd0},
      '{32'sd1, 1'b0, 1'b0, 32'sd0},
      '{VAL_MAX, 1'b0, 1'b0, 32'sd0},
      '{VAL_MIN, 1'b0, 1'b0, 32'sd0},
      '{32'sh5555_5555, 1'b0, 1'b0, 32'sd0},
      '{32'shAAAA_AAAA, 1'b0, 1'b0, 32'sd0},
      '{32'sd0, 1'b1, 1'b0, 32'sd0},
      '{32'sd5, 1'b0, 1'b0, 32'sd0},
      '{32'sd4, 1'b0, 1'b0, 32'sd0},
      '{32'sd3, 1'b0, 1'b0, 32'sd0},
      '{32'sd2, 1'b0, 1'b0, 32'sd0},
      '{32'sd1, 1'b1, 1'b0, 32'sd0},
      '{-32'sd2, 1'b0, 1'b0, 32'sd0},
      '{32'sd7, 1'b1, 1'b0, 32'sd0}
   };

   insertion_sorter #(.CAPACITY(SORT_CAP)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_value        (req_value),
      .req_end_of_set   (req_end_of_set),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_final_res    (rsp_final_res),
      .rsp_overflowed   (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned draw_wait(input bit calm);
      if (calm)
         return 0;
      return $urandom_range(10, 0);
   endfunction

   // Mostly full-range values, with small ones mixed in to force equal keys.
   function automatic data_type pick_value();
      int unsigned roll;
      roll = $urandom_range(9, 0);
      if (roll < 6)
         return data_type'($urandom);
      if (roll < 9)
         return data_type'(int'($urandom_range(8, 0)) - 4);
      case ($urandom_range(3, 0))
         0: return VAL_MIN;
         1: return VAL_MAX;
         2: return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   // Stable insertion: only entries strictly greater than the new value move up.
   function automatic void sort_in(input data_type v, input logic eos);
      int unsigned     pos;
      sorted_beat_type beat;
      if (held_count >= SORT_CAP) begin
         held_dropped = 1'b1;
      end else begin
         pos = held_count;
         while (pos > 0 && held[pos-1] > v) begin
            held[pos] = held[pos-1];
            pos--;
         end
         held[pos] = v;
         held_count++;
      end
      if (eos) begin
         for (int k = 0; k < held_count; k++) begin
            beat.value = held[k];
            beat.last  = (k + 1 == held_count);
            beat.ovf   = held_dropped;
            sorted_due.push_back(beat);
         end
         held_count   = 0;
         held_dropped = 1'b0;
      end
   endfunction

   task automatic offer_beat(input data_type v, input logic eos, input logic typed,
                             input data_type typed_v);
      int unsigned gap;
      gap = draw_wait(send_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_value        <= v;
      req_end_of_set   <= eos;
      beat_typed       <= typed;
      beat_typed_value <= typed_v;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sorted_due.size() != 0);
   endtask

   // Monitor: beats in are predicted before beats out are checked, so both
   // sides of one edge are seen in a fixed order.
   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (beat_typed) begin
               want.value = beat_typed_value;
               want.last  = 1'b1;
               want.ovf   = 1'b0;
               sorted_due.push_back(want);
            end else begin
               sort_in(req_value, req_end_of_set);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (sorted_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: value %0d final %0b overflow %0b",
                           rsp_sorted_value, rsp_final_res, rsp_overflowed);
            end else begin
               want = sorted_due.pop_front();
               if (rsp_sorted_value !== want.value || rsp_final_res !== want.last ||
                   rsp_overflowed !== want.ovf) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("beat %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b", rsp_seen,
                              want.value, want.last, want.ovf,
                              rsp_sorted_value, rsp_final_res, rsp_overflowed);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side: a fresh hold-off is drawn for every beat, with calm stretches.
   initial begin
      int unsigned hold;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         hold = draw_wait(((rsp_seen / 40) % 4) == 2);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin
      int unsigned set_idx;
      int unsigned set_len;
      int unsigned items_sent;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_value        <= '0;
      req_end_of_set   <= 1'b0;
      beat_typed       <= 1'b0;
      beat_typed_value <= '0;
      held_count   = 0;
      held_dropped = 1'b0;
      mismatches   = 0;
      rsp_seen     = 0;
      send_calm    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (probes[i])
         offer_beat(probes[i].value, probes[i].end_of_set, probes[i].typed,
                    probes[i].typed_value);
      hold_until_drained();

      items_sent = NUM_PROBES;
      set_idx    = 0;
      while (items_sent < NUM_ITEMS) begin
         send_calm = (set_idx % 6) == 5;
         // Every eighth set runs close to, up to or past a full chain.
         if (set_idx % 8 == 7) begin
            case ($urandom_range(3, 0))
               0: set_len = SORT_CAP - 1;
               1: set_len = SORT_CAP;
               2: set_len = SORT_CAP + 1;
               default: set_len = $urandom_range(SORT_CAP + 10, SORT_CAP + 2);
            endcase
         end else begin
            set_len = $urandom_range(12, 1);
         end
         for (int i = 0; i < set_len; i++)
            offer_beat(pick_value(), i == set_len - 1, 1'b0, '0);
         items_sent += set_len;
         if (set_idx % 10 == 4)
            hold_until_drained();
         set_idx++;
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sorted_due.size() != 0) begin
         $display("%0d expected beats never arrived", sorted_due.size());
         mismatches += sorted_due.size();
      end
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/isrt_pkg.sv
hw/rtl/isrt_cell.sv
hw/rtl/insertion_sorter.sv
tb/sv/tb_insertion_sorter.sv
